[src/lecm_pkg.sv]
// lecm_pkg: shared types, constants and register codes of the laplacian edge color map
// no dependencies; imported by lecm_front, lecm_back, the top level and the checker
`default_nettype none
package lecm_pkg;

	// default frame limits
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// configuration port
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_GAIN    = 2'd3;

	// register reset values
	localparam logic [12:0] RST_FRAME_WIDTH  = 13'd640;
	localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
	localparam logic        RST_EDGE_MODE    = 1'b1;
	localparam logic [7:0]  RST_EDGE_GAIN    = 8'd1;

	// opcodes
	localparam logic OP_TABLE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// arithmetic constants
	localparam int LUMA_MAX    = 255;
	localparam int TABLE_DEPTH = 256;

	// queue depths
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  luma;
		logic [7:0]  table_index;
		logic [31:0] table_color;
	} in_item_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [31:0] pixel_color;
		logic        last_of_item;
	} out_item_t;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic        edge_mode;
		logic [7:0]  edge_gain;
	} cfg_t;

	// command from front to back: table write or table lookup
	typedef struct packed {
		logic        is_write;
		logic [7:0]  index;
		logic [31:0] color;
		logic [11:0] x;
		logic [11:0] y;
		logic        last;
	} cmd_t;

endpackage
`default_nettype wire

[src/lecm_ram.sv]
// lecm_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none
module lecm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[src/lecm_fifo.sv]
// lecm_fifo: small register fifo with occupancy count
// no dependencies
`default_nettype none
module lecm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic                            full,
	input  wire logic                       rd,
	output logic      [WIDTH-1:0]           rdata,
	output logic                            empty,
	output logic      [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
	assign rdata = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[src/lecm_front.sv]
// lecm_front: raster tracking, line buffers, 3x3 window and laplacian index
// depends on lecm_pkg and lecm_ram; emits table commands to the back part
`default_nettype none
module lecm_front import lecm_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     push,
	input  wire in_item_t item,
	output logic          full,
	output logic          cmd_valid,
	output cmd_t          cmd,
	input  wire logic     cmd_ready
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int XW = $clog2(MAX_WIDTH + 1) + 1;
	localparam int YW = $clog2(MAX_HEIGHT + 1) + 1;

	// raster position and clearing sweep
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW:0]   clr_q;
	logic          clearing_q;

	// stage registers
	logic          v_s1, pix_s1, mode_s1, int_s1, bord_s1;
	logic [7:0]    luma_s1, idx_s1;
	logic [31:0]   color_s1;
	logic [11:0]   x_s1, y_s1;
	logic [CW-1:0] addr_s1;
	logic          v_s2, pix_s2, mode_s2, int_s2, bord_s2;
	logic [7:0]    luma_s2, idx_s2;
	logic [31:0]   color_s2;
	logic [11:0]   x_s2, y_s2;
	logic signed [11:0] diff_s2;
	logic          sec_q;

	logic [7:0]    win_q [6];

	logic [XW-1:0] w_lim, c_x;
	logic [YW-1:0] h_lim, r_y;
	logic          accept, adv, interior, border;
	logic [15:0]   lb_rdata;
	logic [7:0]    top, mid;
	logic [10:0]   nsum, ctr8;
	logic          lb_we;
	logic [CW-1:0] lb_waddr;
	logic [15:0]   lb_wdata;
	logic signed [20:0] prod;
	logic [7:0]    lap_idx;
	logic          a_need, b_need, send_a;

	// saturated frame size
	always_comb begin
		if (cfg.frame_width < 13'd3) begin
			w_lim = XW'(3);
		end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
			w_lim = XW'(MAX_WIDTH);
		end else begin
			w_lim = XW'(cfg.frame_width);
		end
		if (cfg.frame_height < 13'd3) begin
			h_lim = YW'(3);
		end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
			h_lim = YW'(MAX_HEIGHT);
		end else begin
			h_lim = YW'(cfg.frame_height);
		end
	end

	// position classification
	assign c_x      = XW'(col_q);
	assign r_y      = YW'(row_q);
	assign interior = (c_x >= XW'(2)) && (c_x <= w_lim - 1'b1) &&
	                  (r_y >= YW'(2)) && (r_y <= h_lim - 1'b1);
	assign border   = (c_x == '0) || (c_x >= w_lim - 1'b1) ||
	                  (r_y == '0) || (r_y >= h_lim - 1'b1);

	assign accept = push && !full;
	assign full   = clearing_q || !adv;

	// raster counters and line buffer clearing after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == (CW+1)'(MAX_WIDTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (accept && item.opcode == OP_PIXEL) begin
				if (c_x + 1'b1 >= w_lim) begin
					col_q <= '0;
					row_q <= (r_y + 1'b1 >= h_lim) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// line buffers: upper byte two rows above, lower byte one row above
	assign lb_we    = clearing_q || (v_s1 && pix_s1 && adv);
	assign lb_waddr = clearing_q ? clr_q[CW-1:0] : addr_s1;
	assign lb_wdata = clearing_q ? 16'd0 : {mid, luma_s1};

	lecm_ram #(
		.WIDTH(16),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (lb_we),
		.waddr(lb_waddr),
		.wdata(lb_wdata),
		.re   (accept),
		.raddr(col_q),
		.rdata(lb_rdata)
	);

	assign top = lb_rdata[15:8];
	assign mid = lb_rdata[7:0];

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			pix_s1   <= (item.opcode == OP_PIXEL);
			mode_s1  <= cfg.edge_mode;
			int_s1   <= interior;
			bord_s1  <= border;
			luma_s1  <= item.luma;
			idx_s1   <= item.table_index;
			color_s1 <= item.table_color;
			x_s1     <= 12'(col_q);
			y_s1     <= 12'(row_q);
			addr_s1  <= col_q;
		end
	end

	// laplacian difference: eight times centre minus neighbours
	assign nsum = 11'(win_q[0]) + 11'(win_q[2]) + 11'(win_q[3]) + 11'(win_q[4]) +
	              11'(win_q[5]) + 11'(top) + 11'(mid) + 11'(luma_s1);
	assign ctr8 = {win_q[1], 3'b000};

	// window shift on each pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1 && pix_s1 && adv) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= top;
			win_q[1] <= mid;
			win_q[2] <= luma_s1;
		end
	end

	// stage 2 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			pix_s2   <= pix_s1;
			mode_s2  <= mode_s1;
			int_s2   <= int_s1;
			bord_s2  <= bord_s1;
			luma_s2  <= luma_s1;
			idx_s2   <= idx_s1;
			color_s2 <= color_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			diff_s2  <= $signed({1'b0, ctr8}) - $signed({1'b0, nsum});
		end
	end

	// gain and clamp to table range
	assign prod = diff_s2 * $signed({1'b0, cfg.edge_gain});

	always_comb begin
		if (prod < 0) begin
			lap_idx = '0;
		end else if (prod > 21'sd255) begin
			lap_idx = 8'(LUMA_MAX);
		end else begin
			lap_idx = prod[7:0];
		end
	end

	// command issue: interior centre first, then own pixel or table write
	assign a_need = v_s2 && pix_s2 && mode_s2 && int_s2;
	assign b_need = v_s2 && (!pix_s2 || !mode_s2 || bord_s2);
	assign send_a = a_need && !sec_q;
	assign cmd_valid = send_a || b_need;

	always_comb begin
		cmd.color = color_s2;
		if (send_a) begin
			cmd.is_write = 1'b0;
			cmd.index    = lap_idx;
			cmd.x        = x_s2 - 1'b1;
			cmd.y        = y_s2 - 1'b1;
			cmd.last     = !b_need;
		end else begin
			cmd.is_write = !pix_s2;
			cmd.index    = !pix_s2 ? idx_s2 : (mode_s2 ? 8'd0 : luma_s2);
			cmd.x        = x_s2;
			cmd.y        = y_s2;
			cmd.last     = 1'b1;
		end
	end

	assign adv = !v_s2 || (!a_need && !b_need) ||
	             (cmd_ready && !(send_a && b_need));

	// second command pending for a two result pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= 1'b0;
		end else if (adv) begin
			sec_q <= 1'b0;
		end else if (send_a && cmd_ready) begin
			sec_q <= 1'b1;
		end
	end
endmodule
`default_nettype wire

[src/lecm_back.sv]
// lecm_back: color table writes and lookups, result queue
// depends on lecm_pkg, lecm_ram and lecm_fifo
`default_nettype none
module lecm_back import lecm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_avail,
	input  wire cmd_t cmd,
	output logic      cmd_take,
	output logic      empty,
	input  wire logic pop,
	output out_item_t result
);
	localparam int OCW = $clog2(OUT_DEPTH + 1);

	logic            v_b1;
	logic [11:0]     x_b1, y_b1;
	logic            last_b1;
	logic [31:0]     tbl_rdata;
	logic [OCW-1:0]  ocnt;
	logic [OCW:0]    used;
	logic            lookup, tbl_we;
	out_item_t       res_in;
	logic [$bits(out_item_t)-1:0] res_out;

	// take a table write at once, and a lookup only when a result slot is free
	assign used     = (OCW+1)'(ocnt) + (OCW+1)'(v_b1);
	assign cmd_take = cmd_avail && (cmd.is_write || used < (OCW+1)'(OUT_DEPTH));
	assign lookup   = cmd_take && !cmd.is_write;
	assign tbl_we   = cmd_take && cmd.is_write;

	lecm_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(cmd.index),
		.wdata(cmd.color),
		.re   (lookup),
		.raddr(cmd.index),
		.rdata(tbl_rdata)
	);

	// lookup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
		end else begin
			v_b1 <= lookup;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup) begin
			x_b1    <= cmd.x;
			y_b1    <= cmd.y;
			last_b1 <= cmd.last;
		end
	end

	assign res_in = '{pixel_x: x_b1, pixel_y: y_b1, pixel_color: tbl_rdata,
	                  last_of_item: last_b1};

	lecm_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OUT_DEPTH)
	) u_results (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (v_b1),
		.wdata (res_in),
		.full  (),
		.rd    (pop),
		.rdata (res_out),
		.empty (empty),
		.count (ocnt)
	);

	assign result = out_item_t'(res_out);
endmodule
`default_nettype wire

[src/laplacian_edge_color_map.sv]
// laplacian_edge_color_map: top level, configuration registers and front to back queue
// depends on lecm_pkg, lecm_front, lecm_back and lecm_fifo
//
// Usage
// - input channel: drive item and raise push; the beat is taken when full is low.
//   opcode 0 writes one color table entry, opcode 1 delivers the next raster luma pixel.
// - result channel: while empty is low, result holds the oldest result; raise pop to take it.
//   a pixel gives zero, one or two results; last_of_item marks the final one.
// - configuration: cfg_we writes cfg_data to register cfg_index (frame_width,
//   frame_height, edge_mode, edge_gain); write only while the block is idle.
// - throughput: one item per cycle while the queues have room; a pixel with two results holds
//   the input until the front, issuing one command per cycle, has queued its second command.
// - path: an input beat passes the line buffer read, the laplacian, gain and clamp into the
//   command queue, the table read and the result queue before its result shows on the ports.
// - reset: configuration returns to 640x480, edge mode, gain 1; full stays high while the line
//   buffers are swept to zero. Table entries must be written before they are looked up.
// - stall: when pop is held low the result queue fills, then the command queue, then full
//   rises; no beat is lost.
`default_nettype none
module laplacian_edge_color_map import lecm_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire in_item_t              item,
	output logic                       full,
	output logic                       empty,
	input  wire logic                  pop,
	output out_item_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t  cfg_q;
	logic  f_valid, f_ready, q_full, q_empty, q_take;
	cmd_t  f_cmd, q_cmd;
	logic [$bits(cmd_t)-1:0] q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= RST_FRAME_WIDTH;
			cfg_q.frame_height <= RST_FRAME_HEIGHT;
			cfg_q.edge_mode    <= RST_EDGE_MODE;
			cfg_q.edge_gain    <= RST_EDGE_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				REG_EDGE_MODE:    cfg_q.edge_mode    <= cfg_data[0];
				REG_EDGE_GAIN:    cfg_q.edge_gain    <= cfg_data[7:0];
				default:          ;
			endcase
		end
	end

	lecm_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_valid(f_valid),
		.cmd      (f_cmd),
		.cmd_ready(f_ready)
	);

	// command queue between front and back
	assign f_ready = !q_full;

	lecm_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (f_valid),
		.wdata (f_cmd),
		.full  (q_full),
		.rd    (q_take),
		.rdata (q_data),
		.empty (q_empty),
		.count ()
	);

	assign q_cmd = cmd_t'(q_data);

	lecm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_avail(!q_empty),
		.cmd      (q_cmd),
		.cmd_take (q_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);
endmodule
`default_nettype wire

[src/lecm_checker.sv]
// lecm_checker: port level assertions for the laplacian edge color map
// depends on lecm_pkg; bound to laplacian_edge_color_map
`default_nettype none
module lecm_checker import lecm_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  push,
	input wire in_item_t              item,
	input wire logic                  full,
	input wire logic                  empty,
	input wire logic                  pop,
	input wire out_item_t             result,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);
	// a waiting result stays until popped
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn without pop");

	// a waiting result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("result changed while stalled");

	// the line buffer sweep blocks input right after reset
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> full)
		else $error("input open during line buffer sweep");

	// a non-final result is an interior centre, never on row or column zero
	a_first_interior: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.last_of_item |-> result.pixel_x != 12'd0 && result.pixel_y != 12'd0)
		else $error("non-final result outside interior");

	// nothing comes out after reset until something went in
	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty)
		else $error("result present after reset");
endmodule

bind laplacian_edge_color_map lecm_checker u_lecm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.item     (item),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.result   (result),
	.cfg_we   (cfg_we),
	.cfg_index(cfg_index),
	.cfg_data (cfg_data)
);
`default_nettype wire
